>>> rtl/atan_eu_pkg.sv
// Shared constants and types for the Euler-series arctangent core.
// Used by atan_eu_div and arctan_euler_series_core; no dependencies.
`timescale 1ns / 1ps

package atan_eu_pkg;

  localparam int MAX_TERMS       = 40;
  localparam int ANGLE_FRAC_BITS = 30;

  // Internal fraction bits of the Q1.31 datapath.
  localparam int FB = 31;

  // Series index width; k runs 1 .. MAX_TERMS-1.
  localparam int KW = $clog2(MAX_TERMS);

  // Divider: left-justified numerator, one quotient bit per cycle.
  localparam int DIV_W  = 64;
  localparam int DEN_W  = 33;
  localparam int QUO_W  = 32;
  localparam int ITER_W = $clog2(DIV_W) + 1;

  // Significant numerator bits per division kind.
  localparam int RCP_W  = 48;          // 2^47 + mag/2
  localparam int TNUM_W = 33 + KW;     // t*2k + k

  localparam logic [32:0] ONE_Q31  = 33'h0_8000_0000;
  localparam logic [32:0] PI_2_Q31 = 33'd3373259426;

  typedef struct packed {
    logic                  start;
    logic [ITER_W-1:0]     iters;
    logic [DIV_W-1:0]      num;
    logic [DEN_W-1:0]      den;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [QUO_W-1:0]      quo;
  } div_rsp_t;

endpackage

>>> rtl/atan_eu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on atan_eu_pkg (request/response structs, widths).
`timescale 1ns / 1ps

module atan_eu_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atan_eu_pkg::div_req_t req_i,
  output atan_eu_pkg::div_rsp_t rsp_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [atan_eu_pkg::ITER_W-1:0]  cnt_q, cnt_d;
  logic [atan_eu_pkg::DIV_W-1:0]   num_q, num_d;
  logic [atan_eu_pkg::DEN_W-1:0]   den_q, den_d;
  logic [atan_eu_pkg::DEN_W-1:0]   rem_q, rem_d;
  logic [atan_eu_pkg::QUO_W-1:0]   quo_q, quo_d;

  logic [atan_eu_pkg::DEN_W:0]     rem_sh;
  logic                            ge;

  // remainder stays below the divisor, so one extra bit covers the shift
  assign rem_sh = {rem_q, num_q[atan_eu_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = req_i.iters;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? atan_eu_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                 : rem_sh[atan_eu_pkg::DEN_W-1:0];
      quo_d = {quo_q[atan_eu_pkg::QUO_W-2:0], ge};
      num_d = {num_q[atan_eu_pkg::DIV_W-2:0], 1'b0};
      cnt_d = cnt_q - atan_eu_pkg::ITER_W'(1);
      if (cnt_q == atan_eu_pkg::ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> rtl/arctan_euler_series_core.sv
// Arctangent core: Euler series on one shared multiplier and one shared divider.
// Depends on atan_eu_pkg and atan_eu_div.
`timescale 1ns / 1ps

// Usage:
//   Drive tangent_i (signed Q16.16) and raise start; the request is taken at
//   the clock edge where start is high and busy is low. busy stays high while
//   the sequencer works and drops in the same cycle that valid_o pulses.
//   valid_o is high for exactly one cycle with angle_o (signed Q1.30 radians);
//   the receiver must take it then, it is not held.
// Work: a request runs the series terms, with an extra reciprocal division
//   when |tangent| > 1. Each term costs a multiply, a rounding step, a second
//   multiply and a pass of the bit-serial divider; the term count is at most
//   MAX_TERMS-1 and ends early once a term rounds to zero.
// Throughput: one request at a time; a new one may be taken in the cycle
//   valid_o is high.
// Reset: rst_ni low returns the sequencer to idle, drops busy and valid_o;
//   no request in flight survives.

module arctan_euler_series_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [31:0] tangent_i,
  output logic        busy,
  output logic        valid_o,
  output logic [31:0] angle_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_RDIV  = 17'h00002,
    S_RWAIT = 17'h00004,
    S_SQR   = 17'h00008,
    S_X2    = 17'h00010,
    S_QDIV  = 17'h00020,
    S_QWAIT = 17'h00040,
    S_TMUL  = 17'h00080,
    S_TRND  = 17'h00100,
    S_TMUL2 = 17'h00200,
    S_TDIV  = 17'h00400,
    S_TWAIT = 17'h00800,
    S_FDIV  = 17'h01000,
    S_FWAIT = 17'h02000,
    S_AMUL  = 17'h04000,
    S_AFIN  = 17'h08000,
    S_OUT   = 17'h10000
  } state_e;

  localparam int OSH = atan_eu_pkg::FB - atan_eu_pkg::ANGLE_FRAC_BITS;

  state_e state_q, state_d;

  logic                        neg_q, neg_d;
  logic                        big_q, big_d;
  logic [31:0]                 mag_q, mag_d;
  logic [31:0]                 x_q, x_d;
  logic [31:0]                 x2_q, x2_d;
  logic [30:0]                 q_q, q_d;
  logic [30:0]                 f_q, f_d;
  logic [31:0]                 term_q, term_d;
  logic [31:0]                 t_q, t_d;
  logic [32:0]                 sum_q, sum_d;
  logic [32:0]                 a_q, a_d;
  logic [atan_eu_pkg::KW-1:0]  k_q, k_d;
  logic                        valid_q, valid_d;
  logic [31:0]                 angle_q, angle_d;

  logic [32:0]                 mul_a, mul_b;
  logic [65:0]                 p_q;
  logic [65:0]                 p_rnd;
  logic [32:0]                 d_w;
  logic [31:0]                 mag_w;
  logic [32:0]                 a_w;
  logic [32:0]                 r_w;
  logic [63:0]                 tnum;

  atan_eu_pkg::div_req_t div_req;
  atan_eu_pkg::div_rsp_t div_rsp;

  atan_eu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared multiplier, product registered
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  assign p_rnd = p_q + 66'(1 << (atan_eu_pkg::FB - 1));
  assign d_w   = atan_eu_pkg::ONE_Q31 + {1'b0, x2_q};
  assign mag_w = tangent_i[31] ? (32'd0 - tangent_i) : tangent_i;
  assign tnum  = p_q[63:0] + 64'(k_q);
  assign a_w   = p_rnd[63:31];
  assign r_w   = (a_q + 33'(1 << (OSH - 1))) >> OSH;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQR: begin
        mul_a = {1'b0, x_q};
        mul_b = {1'b0, x_q};
      end
      S_TMUL: begin
        mul_a = {1'b0, term_q};
        mul_b = {2'b00, q_q};
      end
      S_TMUL2: begin
        mul_a = {1'b0, t_q};
        mul_b = 33'({k_q, 1'b0});
      end
      S_AMUL: begin
        mul_a = {2'b00, f_q};
        mul_b = sum_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divider operands; numerators carry half the divisor for round-to-nearest
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = atan_eu_pkg::ITER_W'(atan_eu_pkg::DIV_W);
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      S_RDIV: begin
        div_req.start = 1'b1;
        div_req.iters = atan_eu_pkg::ITER_W'(atan_eu_pkg::RCP_W);
        div_req.num   = (64'(1) << 47) + 64'(mag_q >> 1);
        div_req.num   = div_req.num << (atan_eu_pkg::DIV_W - atan_eu_pkg::RCP_W);
        div_req.den   = {1'b0, mag_q};
      end
      S_QDIV: begin
        div_req.start = 1'b1;
        div_req.num   = (64'(x2_q) << atan_eu_pkg::FB) + 64'(d_w >> 1);
        div_req.den   = d_w;
      end
      S_TDIV: begin
        div_req.start = 1'b1;
        div_req.iters = atan_eu_pkg::ITER_W'(atan_eu_pkg::TNUM_W);
        div_req.num   = tnum << (atan_eu_pkg::DIV_W - atan_eu_pkg::TNUM_W);
        div_req.den   = 33'({k_q, 1'b1});
      end
      S_FDIV: begin
        div_req.start = 1'b1;
        div_req.num   = (64'(x_q) << atan_eu_pkg::FB) + 64'(d_w >> 1);
        div_req.den   = d_w;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    big_d   = big_q;
    mag_d   = mag_q;
    x_d     = x_q;
    x2_d    = x2_q;
    q_d     = q_q;
    f_d     = f_q;
    term_d  = term_q;
    t_d     = t_q;
    sum_d   = sum_q;
    a_d     = a_q;
    k_d     = k_q;
    valid_d = 1'b0;
    angle_d = angle_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          neg_d = tangent_i[31];
          mag_d = mag_w;
          big_d = mag_w > 32'd65536;
          x_d   = mag_w << 15;
          state_d = (mag_w > 32'd65536) ? S_RDIV : S_SQR;
        end
      end
      S_RDIV:  state_d = S_RWAIT;
      S_RWAIT: begin
        if (div_rsp.done) begin
          x_d     = div_rsp.quo;
          state_d = S_SQR;
        end
      end
      S_SQR:   state_d = S_X2;
      S_X2: begin
        x2_d    = p_rnd[62:31];
        state_d = S_QDIV;
      end
      S_QDIV:  state_d = S_QWAIT;
      S_QWAIT: begin
        if (div_rsp.done) begin
          q_d     = div_rsp.quo[30:0];
          term_d  = atan_eu_pkg::ONE_Q31[31:0];
          sum_d   = atan_eu_pkg::ONE_Q31;
          k_d     = atan_eu_pkg::KW'(1);
          state_d = S_TMUL;
        end
      end
      S_TMUL:  state_d = S_TRND;
      S_TRND: begin
        t_d     = p_rnd[62:31];
        state_d = S_TMUL2;
      end
      S_TMUL2: state_d = S_TDIV;
      S_TDIV:  state_d = S_TWAIT;
      S_TWAIT: begin
        if (div_rsp.done) begin
          term_d = div_rsp.quo;
          if (div_rsp.quo == '0) begin
            state_d = S_FDIV;
          end else begin
            sum_d = sum_q + {1'b0, div_rsp.quo};
            if (k_q == atan_eu_pkg::KW'(atan_eu_pkg::MAX_TERMS - 1)) begin
              state_d = S_FDIV;
            end else begin
              k_d     = k_q + atan_eu_pkg::KW'(1);
              state_d = S_TMUL;
            end
          end
        end
      end
      S_FDIV:  state_d = S_FWAIT;
      S_FWAIT: begin
        if (div_rsp.done) begin
          f_d     = div_rsp.quo[30:0];
          state_d = S_AMUL;
        end
      end
      S_AMUL:  state_d = S_AFIN;
      S_AFIN: begin
        // reciprocal path: angle = pi/2 - a, floored at zero
        if (big_q) begin
          a_d = (a_w <= atan_eu_pkg::PI_2_Q31) ? (atan_eu_pkg::PI_2_Q31 - a_w) : '0;
        end else begin
          a_d = a_w;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        angle_d = neg_q ? (32'd0 - r_w[31:0]) : r_w[31:0];
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    big_q   <= big_d;
    mag_q   <= mag_d;
    x_q     <= x_d;
    x2_q    <= x2_d;
    q_q     <= q_d;
    f_q     <= f_d;
    term_q  <= term_d;
    t_q     <= t_d;
    sum_q   <= sum_d;
    a_q     <= a_d;
    angle_q <= angle_d;
  end

  assign busy    = state_q != S_IDLE;
  assign valid_o = valid_q;
  assign angle_o = angle_q;

  // result strobe coincides with the return to idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result strobe while busy");

  // an accepted request always leads to a busy cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but core idle");

  // divider is only started when it is free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  // series index stays inside the term budget
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TWAIT) |-> (k_q != '0 &&
      k_q <= atan_eu_pkg::KW'(atan_eu_pkg::MAX_TERMS - 1)))
    else $error("series index out of range");

endmodule
